### rtl/core/single_source_shortest_paths_macros.svh
// Assertion macros for the shortest path block.
// Each macro expects aclk and aresetn in the scope of the module that uses it.
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SSSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sssp_pkg.sv
// Package for the shortest path block: field widths, register indexes,
// memory entry types and the distance saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sssp_pkg;

    localparam int VERTEX_W          = 6;
    localparam int DIST_W            = 24;
    localparam int WEIGHT_W          = 16;
    localparam int SUM_W             = DIST_W + 1;
    localparam int MAX_VERTICES      = 64;
    localparam int DEFAULT_MAX_EDGES = 256;
    localparam int VCOUNT_W          = 7;
    localparam int ECOUNT_W          = 9;
    localparam int CFG_DATA_W        = 9;
    localparam int TDATA_W           = 40;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(64);

    // configuration register indexes
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_EDGE_COUNT   = 1'b1;

    // input selector
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic [VERTEX_W-1:0]        to;
        logic [VERTEX_W-1:0]        from;
    } edge_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]      pred;
        logic signed [DIST_W-1:0] cost;
    } vertex_t;

    function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [SUM_W-1:0] x);
        logic signed [DIST_W-1:0] r;
        if (x[SUM_W-1] != x[SUM_W-2]) begin
            r = x[SUM_W-1] ? DIST_MIN : DIST_MAX;
        end else begin
            r = x[DIST_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/single_source_shortest_paths.sv
// Single-source shortest paths (Bellman-Ford) over a loaded edge list. A transfer with
// tuser 0 stores one edge at the next free slot of the edge memory, one per cycle while
// idle; edges past MAX_EDGES are dropped. A transfer with tuser 1 starts a run from the
// given vertex: a set-up step, then vertex_count-1 relaxation passes and one check pass
// over the first edge_count edges, each edge read from the edge memory, then both ends
// read from the vertex memory, then compared and written back. A run without a negative
// cycle then gives one result per vertex; a detected cycle gives a single result with
// tuser set. The sequential read-modify-write of the vertex memory per edge sets the run
// length; no edge starts before the previous write has landed.
// Depends on sssp_pkg and single_source_shortest_paths_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module single_source_shortest_paths #(
    parameter int MAX_EDGES = sssp_pkg::DEFAULT_MAX_EDGES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // edge_from[5:0], edge_to[11:6], edge_weight[27:12], start_vertex[33:28], zero fill
    input  wire logic [sssp_pkg::TDATA_W-1:0]    s_tdata,
    // mode[0]
    input  wire logic                            s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // vertex_index[5:0], path_distance[29:6], predecessor[35:30], reachable[36], zero fill
    output logic [sssp_pkg::TDATA_W-1:0]         m_tdata,
    // negative_cycle[0]
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wen,
    input  wire logic                            cfg_index,
    input  wire logic [sssp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LOAD_W = $clog2(MAX_EDGES + 1);
    localparam int VW     = sssp_pkg::VERTEX_W;
    localparam int CW     = sssp_pkg::VCOUNT_W;
    localparam int EW     = sssp_pkg::ECOUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_NEXT,
        S_DREAD,
        S_RELAX,
        S_OREAD,
        S_OWRITE,
        S_NEG
    } state_t;

    state_t state_reg;

    logic [CW-1:0]     vertex_count_reg;
    logic [EW-1:0]     edge_count_reg;
    logic [LOAD_W-1:0] edges_loaded_reg;
    logic [VW-1:0]     start_reg;
    logic [CW-1:0]     pass_reg;
    logic [EW-1:0]     edge_idx_reg;
    logic              check_reg;
    logic [VW-1:0]     out_idx_reg;
    logic [sssp_pkg::MAX_VERTICES-1:0] reached_reg;

    logic                            m_tvalid_reg;
    logic                            m_tlast_reg;
    logic                            m_neg_reg;
    logic [VW-1:0]                   m_vertex_reg;
    logic signed [sssp_pkg::DIST_W-1:0] m_dist_reg;
    logic [VW-1:0]                   m_pred_reg;
    logic                            m_reach_reg;

    // memories
    sssp_pkg::edge_t   edge_mem [MAX_EDGES];
    sssp_pkg::vertex_t vert_mem [sssp_pkg::MAX_VERTICES];
    sssp_pkg::edge_t   edge_q_reg;
    sssp_pkg::vertex_t vert_a_reg;
    sssp_pkg::vertex_t vert_b_reg;

    // input fields
    sssp_pkg::edge_t in_edge;
    logic [VW-1:0]   in_start;
    logic            in_accept;
    logic            load_ok;

    // run limits
    logic [CW-1:0] vc;
    logic [EW-1:0] ec;

    // vertex memory ports
    logic              vert_we;
    logic [VW-1:0]     vert_waddr;
    sssp_pkg::vertex_t vert_wdata;
    logic              vert_re;
    logic [VW-1:0]     vert_addr_a;

    // relaxation
    logic [VW-1:0]                      rel_u;
    logic [VW-1:0]                      rel_v;
    logic signed [sssp_pkg::SUM_W-1:0]  rel_sum;
    logic                               rel_hit;
    logic                               out_free;
    logic                               out_load;
    logic                               out_last;
    logic                               start_ok;

    assign in_edge.from   = s_tdata[VW-1:0];
    assign in_edge.to     = s_tdata[2*VW-1:VW];
    assign in_edge.weight = s_tdata[2*VW+sssp_pkg::WEIGHT_W-1:2*VW];
    assign in_start       = s_tdata[3*VW+sssp_pkg::WEIGHT_W-1:2*VW+sssp_pkg::WEIGHT_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign load_ok   = in_accept && (s_tuser == sssp_pkg::MODE_LOAD)
                       && (edges_loaded_reg < LOAD_W'(MAX_EDGES));

    always_comb begin
        if (vertex_count_reg == '0) begin
            vc = CW'(1);
        end else if (int'(vertex_count_reg) > sssp_pkg::MAX_VERTICES) begin
            vc = CW'(sssp_pkg::MAX_VERTICES);
        end else begin
            vc = vertex_count_reg;
        end
        if (int'(edge_count_reg) > MAX_EDGES) begin
            ec = EW'(MAX_EDGES);
        end else begin
            ec = edge_count_reg;
        end
    end

    assign start_ok = ({1'b0, start_reg} < vc);

    assign rel_u   = edge_q_reg.from;
    assign rel_v   = edge_q_reg.to;
    assign rel_sum = sssp_pkg::SUM_W'(vert_a_reg.cost) + sssp_pkg::SUM_W'(edge_q_reg.weight);
    assign rel_hit = ({1'b0, rel_u} < vc) && ({1'b0, rel_v} < vc) && reached_reg[rel_u]
                     && (!reached_reg[rel_v]
                         || (rel_sum < sssp_pkg::SUM_W'(vert_b_reg.cost)));

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free && ((state_reg == S_OWRITE) || (state_reg == S_NEG));
    assign out_last = ({1'b0, out_idx_reg} + CW'(1) == vc);

    always_comb begin
        vert_we          = 1'b0;
        vert_waddr       = rel_v;
        vert_wdata.pred  = rel_u;
        vert_wdata.cost  = sssp_pkg::sat_dist(rel_sum);
        vert_re          = 1'b0;
        vert_addr_a      = rel_u;
        case (state_reg)
            S_INIT: begin
                vert_we         = start_ok;
                vert_waddr      = start_reg;
                vert_wdata.pred = '0;
                vert_wdata.cost = '0;
            end
            S_DREAD: begin
                vert_re = 1'b1;
            end
            S_RELAX: begin
                vert_we = rel_hit && !check_reg;
            end
            S_OREAD: begin
                vert_re     = 1'b1;
                vert_addr_a = out_idx_reg;
            end
            default: begin
                vert_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_ok) begin
            edge_mem[EA_W'(edges_loaded_reg)] <= in_edge;
        end
        if (state_reg == S_NEXT) begin
            edge_q_reg <= edge_mem[EA_W'(edge_idx_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (vert_we) begin
            vert_mem[vert_waddr] <= vert_wdata;
        end
        if (vert_re) begin
            vert_a_reg <= vert_mem[vert_addr_a];
            vert_b_reg <= vert_mem[rel_v];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            vertex_count_reg <= sssp_pkg::VCOUNT_RESET;
            edge_count_reg   <= '0;
            edges_loaded_reg <= '0;
            reached_reg      <= '0;
            check_reg        <= 1'b0;
            pass_reg         <= '0;
            edge_idx_reg     <= '0;
            out_idx_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    sssp_pkg::CFG_VERTEX_COUNT: vertex_count_reg <= cfg_wdata[CW-1:0];
                    sssp_pkg::CFG_EDGE_COUNT:   edge_count_reg   <= cfg_wdata[EW-1:0];
                    default:                    edge_count_reg   <= edge_count_reg;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (load_ok) begin
                edges_loaded_reg <= edges_loaded_reg + LOAD_W'(1);
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_accept && (s_tuser == sssp_pkg::MODE_RUN)) begin
                        start_reg <= in_start;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT: begin
                    reached_reg  <= {{(sssp_pkg::MAX_VERTICES-1){1'b0}}, start_ok}
                                    << start_reg;
                    pass_reg     <= '0;
                    edge_idx_reg <= '0;
                    check_reg    <= 1'b0;
                    state_reg    <= S_NEXT;
                end
                S_NEXT: begin
                    if (!check_reg && (pass_reg + CW'(1) >= vc)) begin
                        check_reg    <= 1'b1;
                        edge_idx_reg <= '0;
                    end else if (edge_idx_reg == ec) begin
                        if (check_reg) begin
                            out_idx_reg <= '0;
                            state_reg   <= S_OREAD;
                        end else begin
                            pass_reg     <= pass_reg + CW'(1);
                            edge_idx_reg <= '0;
                        end
                    end else begin
                        state_reg <= S_DREAD;
                    end
                end
                S_DREAD: begin
                    state_reg <= S_RELAX;
                end
                S_RELAX: begin
                    edge_idx_reg <= edge_idx_reg + EW'(1);
                    if (rel_hit) begin
                        reached_reg[rel_v] <= 1'b1;
                    end
                    if (rel_hit && check_reg) begin
                        state_reg <= S_NEG;
                    end else begin
                        state_reg <= S_NEXT;
                    end
                end
                S_OREAD: begin
                    state_reg <= S_OWRITE;
                end
                S_OWRITE: begin
                    if (out_free) begin
                        m_tlast_reg  <= out_last;
                        m_neg_reg    <= 1'b0;
                        m_vertex_reg <= out_idx_reg;
                        m_reach_reg  <= reached_reg[out_idx_reg];
                        m_dist_reg   <= reached_reg[out_idx_reg] ? vert_a_reg.cost : '0;
                        m_pred_reg   <= reached_reg[out_idx_reg] ? vert_a_reg.pred : '0;
                        out_idx_reg  <= out_idx_reg + VW'(1);
                        state_reg    <= out_last ? S_IDLE : S_OREAD;
                    end
                end
                S_NEG: begin
                    if (out_free) begin
                        m_tlast_reg  <= 1'b1;
                        m_neg_reg    <= 1'b1;
                        m_vertex_reg <= '0;
                        m_reach_reg  <= 1'b0;
                        m_dist_reg   <= '0;
                        m_pred_reg   <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_neg_reg;
    assign m_tdata  = {(sssp_pkg::TDATA_W - 2*VW - sssp_pkg::DIST_W - 1)'(0),
                       m_reach_reg, m_pred_reg, m_dist_reg, m_vertex_reg};

`include "single_source_shortest_paths_macros.svh"

    `SSSP_ASSERT_NOW(a_load_bound, 1'b1, int'(edges_loaded_reg) <= MAX_EDGES, "load overflow")
    `SSSP_ASSERT_NOW(a_check_no_write, (state_reg == S_RELAX) && check_reg, !vert_we, "check write")
    `SSSP_ASSERT_NOW(a_neg_last, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "bad cycle result")
    `SSSP_ASSERT_NEXT(a_out_idx, state_reg == S_OREAD, {1'b0, out_idx_reg} < vc, "index past count")

endmodule

`default_nettype wire
